// File: hw/rtl/epm_pkg.sv
// Shared types, constants and saturation helpers for the encoder PI motor PWM unit.
`timescale 1ns / 1ps

package epm_pkg;

  // Channel widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_W       = 48;   // encoder_count(16) + set_point(32)
  localparam int OUT_W      = 80;   // 15 + 15 + 16 + 32 = 78, padded to bytes

  // Datapath widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 64;
  localparam int ESUM_W = 48;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_TOP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION     = 3'd6;

  // Direction sign codes
  localparam logic [1:0] DIR_ZERO = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG2 = 2'b10;
  localparam logic [1:0] DIR_NEG1 = 2'b11;

  // Mode codes
  localparam logic MODE_OPEN   = 1'b0;
  localparam logic MODE_CLOSED = 1'b1;

  // Reset values
  localparam logic signed [31:0] DRIVE_SCALE_RST = 32'sd65536;
  localparam logic [15:0]        TICK_PERIOD_RST = 16'd65;
  localparam logic [15:0]        TIMER_TOP_RST   = 16'd1000;

  localparam logic [14:0] MAG_MAX = 15'h7FFF;

  typedef struct packed {
    logic                mode;
    logic signed [31:0]  prop_gain;
    logic signed [31:0]  integral_gain;
    logic signed [31:0]  drive_scale;
    logic [15:0]         tick_period;
    logic [15:0]         timer_top;
    logic signed [1:0]   direction;
  } cfg_t;

  localparam logic signed [48:0] S32_MAX = {{18{1'b0}}, {31{1'b1}}};
  localparam logic signed [48:0] S32_MIN = {{18{1'b1}}, {31{1'b0}}};
  localparam logic signed [48:0] S48_MAX = {2'b00, {47{1'b1}}};
  localparam logic signed [48:0] S48_MIN = {2'b11, {47{1'b0}}};

  function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) r = S32_MAX[31:0];
    else if (x < S32_MIN) r = S32_MIN[31:0];
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
    logic signed [47:0] r;
    if (x > S48_MAX) r = S48_MAX[47:0];
    else if (x < S48_MIN) r = S48_MIN[47:0];
    else r = x[47:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/epm_cfg.sv
// Configuration register file for the encoder PI motor PWM unit.
`timescale 1ns / 1ps

module epm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [epm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [epm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output epm_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= epm_pkg::MODE_OPEN;
      cfg.prop_gain     <= '0;
      cfg.integral_gain <= '0;
      cfg.drive_scale   <= epm_pkg::DRIVE_SCALE_RST;
      cfg.tick_period   <= epm_pkg::TICK_PERIOD_RST;
      cfg.timer_top     <= epm_pkg::TIMER_TOP_RST;
      cfg.direction     <= epm_pkg::DIR_POS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        epm_pkg::REG_MODE:          cfg.mode          <= cfg_data[0];
        epm_pkg::REG_PROP_GAIN:     cfg.prop_gain     <= cfg_data;
        epm_pkg::REG_INTEGRAL_GAIN: cfg.integral_gain <= cfg_data;
        epm_pkg::REG_DRIVE_SCALE:   cfg.drive_scale   <= cfg_data;
        epm_pkg::REG_TICK_PERIOD:   cfg.tick_period   <= cfg_data[15:0];
        epm_pkg::REG_TIMER_TOP:     cfg.timer_top     <= cfg_data[15:0];
        epm_pkg::REG_DIRECTION:     cfg.direction     <= cfg_data[1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

endmodule

// File: hw/rtl/epm_mul.sv
// Shared signed 33x33 multiplier with registered product.
`timescale 1ns / 1ps

module epm_mul (
  input  logic                                 clk,
  input  logic signed [epm_pkg::MUL_W-1:0]     a,
  input  logic signed [epm_pkg::MUL_W-1:0]     b,
  output logic signed [epm_pkg::PROD_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: hw/rtl/encoder_pi_motor_pwm_unit.sv
// Top level: encoder speed, PI velocity law and H-bridge PWM compare values.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | s_tdata: encoder_count, set_point
//  m_*     | out | m_tvalid / m_tready  | m_tdata: compare_a, compare_b,
//          |     |                      |          measured_speed, drive_level
//  cfg_*   | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// Each tick passes through the one shared 33x33 multiplier before its result
// is valid: seven products in closed mode, three in open mode. s_tready is
// high only while the sequencer is idle, so the next tick is not taken before
// the current one has been handed to the output register.
// A finished result sits in the output register; the next tick can be taken
// while it waits, and only the final step stalls until the register is free.
// Reset (rst, synchronous): registers to their defaults, stored count, error
// integrator and drive cleared, no result pending.
`timescale 1ns / 1ps

module encoder_pi_motor_pwm_unit (
  input  logic                              clk,
  input  logic                              rst,
  // input ticks
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [epm_pkg::IN_W-1:0]          s_tdata,   // [15:0] encoder_count, [47:16] set_point
  // results
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [epm_pkg::OUT_W-1:0]         m_tdata,   // [14:0] compare_a, [29:15] compare_b,
                                                       // [45:30] measured_speed,
                                                       // [77:46] drive_level, [79:78] zero
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [epm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [epm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Sequencer states, one-hot
  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_SPEED = 15'b000000000000010,  // speed, error, open-mode drive
    ST_SUM   = 15'b000000000000100,  // integrator update
    ST_ILO   = 15'b000000000001000,  // esum low word * tick_period
    ST_IHI   = 15'b000000000010000,  // esum high word * tick_period
    ST_IACC  = 15'b000000000100000,  // combine; issue prop_gain * err
    ST_ITIME = 15'b000000001000000,  // itime saturate; latch P term
    ST_IMUL  = 15'b000000010000000,  // issue integral_gain * itime
    ST_DRIVE = 15'b000000100000000,  // drive = sat32(P + I)
    ST_SCALE = 15'b000001000000000,  // issue drive * drive_scale
    ST_SREG  = 15'b000010000000000,  // latch scaled drive
    ST_SLO   = 15'b000100000000000,  // scaled low word * timer_top
    ST_SHI   = 15'b001000000000000,  // scaled high word * timer_top
    ST_SACC  = 15'b010000000000000,  // combine timer count
    ST_FIN   = 15'b100000000000000   // magnitude, channel select, output
  } state_t;

  state_t state, state_next;

  epm_pkg::cfg_t cfg;

  epm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic signed [epm_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [epm_pkg::PROD_W-1:0] prod;

  epm_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Tick payload
  logic [15:0]         raw_count;
  logic signed [31:0]  set_point;

  // Architectural state
  logic [15:0]                        prev_count;
  logic signed [epm_pkg::ESUM_W-1:0]  esum;
  logic signed [31:0]                 drive_value;

  // Working registers
  logic [15:0]                        speed;
  logic signed [31:0]                 err;
  logic signed [31:0]                 itime;
  logic signed [epm_pkg::ACC_W-1:0]   acc;

  // Speed and error
  logic [15:0]         now_count;
  logic [15:0]         delta;
  logic signed [33:0]  err_wide;

  always_comb begin
    unique case (cfg.direction)
      epm_pkg::DIR_POS:  now_count = raw_count;
      epm_pkg::DIR_NEG1: now_count = 16'(16'd0 - raw_count);
      epm_pkg::DIR_NEG2: now_count = 16'(16'd0 - {raw_count[14:0], 1'b0});
      epm_pkg::DIR_ZERO: now_count = '0;
      default:           now_count = '0;
    endcase
  end

  assign delta    = now_count - prev_count;
  assign err_wide = {{2{set_point[31]}}, set_point} - {{2{delta[15]}}, delta, 16'd0};

  // Final count: truncate toward zero, saturate magnitude
  logic        c_neg;
  logic [63:0] c_abs;
  logic [14:0] mag;
  logic        to_b;

  assign c_neg = acc[63];
  assign c_abs = c_neg ? (~acc + 64'd1) : acc;
  assign mag   = (|c_abs[63:31]) ? epm_pkg::MAG_MAX : c_abs[30:16];
  assign to_b  = c_neg ^ cfg.direction[1];

  // Multiplier operand select
  always_comb begin
    unique case (state)
      ST_ILO: begin
        mul_a = {1'b0, esum[31:0]};
        mul_b = {17'd0, cfg.tick_period};
      end
      ST_IHI: begin
        mul_a = {{17{esum[47]}}, esum[47:32]};
        mul_b = {17'd0, cfg.tick_period};
      end
      ST_IACC: begin
        mul_a = {cfg.prop_gain[31], cfg.prop_gain};
        mul_b = {err[31], err};
      end
      ST_IMUL: begin
        mul_a = {cfg.integral_gain[31], cfg.integral_gain};
        mul_b = {itime[31], itime};
      end
      ST_SCALE: begin
        mul_a = {drive_value[31], drive_value};
        mul_b = {cfg.drive_scale[31], cfg.drive_scale};
      end
      ST_SLO: begin
        mul_a = {1'b0, acc[31:0]};
        mul_b = {17'd0, cfg.timer_top};
      end
      ST_SHI: begin
        mul_a = {{17{acc[47]}}, acc[47:32]};
        mul_b = {17'd0, cfg.timer_top};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_SPEED;
      ST_SPEED: state_next = (cfg.mode == epm_pkg::MODE_CLOSED) ? ST_SUM : ST_SCALE;
      ST_SUM:   state_next = ST_ILO;
      ST_ILO:   state_next = ST_IHI;
      ST_IHI:   state_next = ST_IACC;
      ST_IACC:  state_next = ST_ITIME;
      ST_ITIME: state_next = ST_IMUL;
      ST_IMUL:  state_next = ST_DRIVE;
      ST_DRIVE: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_SREG;
      ST_SREG:  state_next = ST_SLO;
      ST_SLO:   state_next = ST_SHI;
      ST_SHI:   state_next = ST_SACC;
      ST_SACC:  state_next = ST_FIN;
      ST_FIN:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      prev_count  <= '0;
      esum        <= '0;
      drive_value <= '0;
    end else begin
      state <= state_next;
      if (state == ST_FIN && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (state == ST_SPEED) begin
        prev_count <= now_count;
        if (cfg.mode == epm_pkg::MODE_OPEN) drive_value <= set_point;
      end
      if (state == ST_SUM)
        esum <= epm_pkg::sat48({esum[47], esum} + {{17{err[31]}}, err});
      if (state == ST_DRIVE)
        drive_value <= epm_pkg::sat32({acc[47], acc[47:0]} + {prod[63], prod[63:16]});
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      raw_count <= s_tdata[15:0];
      set_point <= s_tdata[47:16];
    end
    if (state == ST_SPEED) begin
      speed <= delta;
      err   <= epm_pkg::sat32({{15{err_wide[33]}}, err_wide});
    end
    unique case (state) inside
      ST_IHI, ST_SHI:    acc <= prod[63:0];
      ST_IACC, ST_SACC:  acc <= acc + {prod[31:0], 32'd0};
      ST_ITIME, ST_SREG: acc <= {{14{prod[65]}}, prod[65:16]};
      default: ;
    endcase
    if (state == ST_ITIME) itime <= epm_pkg::sat32({acc[63], acc[63:16]});
    if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, drive_value, speed,
                  (to_b ? mag : 15'd0), (to_b ? 15'd0 : mag)};
    end
  end

endmodule
